// File: src/tdmt_pkg.sv
package tdmt_pkg;

   // Table geometry
   localparam int SLOTS     = 10;
   localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W     = $clog2(SLOTS + 1);

   // Field widths
   localparam int ACTION_W  = 2;
   localparam int MSG_W     = 6;
   localparam int TIME_W    = 32;
   localparam int SLOT_W    = 4;
   localparam int OUTCOME_W = 2;
   localparam int ACTIVE_W  = 4;
   localparam int TIMEOUT_W = 8;

   // Width used to compare a requested slot against the fill count
   localparam int CMP_W     = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   // Timeout in milliseconds: seconds times a constant below 2**10
   localparam int MS_PER_S        = 1000;
   localparam int LIMIT_W         = TIMEOUT_W + 10;
   localparam int DEFAULT_TIMEOUT = 5;

   // Stream packing
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = OUTCOME_W + 1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SHOW = 2'd0,
      ACT_TICK = 2'd1,
      ACT_READ = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_INSERTED  = 2'd0,
      OUT_REFRESHED = 2'd1,
      OUT_DROPPED   = 2'd2,
      OUT_OTHER     = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHOW,
      ST_TICK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        load;
      logic        step;
      logic        refresh;
      logic        insert;
      logic        copy;
      logic        commit;
      logic        set_outcome;
      outcome_type outcome;
      logic        emit;
   } dp_cmd_type;

   typedef struct packed {
      logic walk_done;
      logic match;
      logic keep;
      logic full;
      logic rsp_free;
   } dp_status_type;

endpackage

// File: src/tdmt_ctrl.sv
module tdmt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic [tdmt_pkg::ACTION_W-1:0] req_action,
   output logic                     req_tready,
   input  tdmt_pkg::dp_status_type  status,
   output tdmt_pkg::dp_cmd_type     cmd
);

   tdmt_pkg::state_type state_ff;
   tdmt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdmt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_tready      = 1'b0;
      cmd             = '0;
      cmd.outcome     = tdmt_pkg::OUT_OTHER;
      case (state_ff)
         tdmt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               case (tdmt_pkg::action_type'(req_action))
                  tdmt_pkg::ACT_SHOW: state_in = tdmt_pkg::ST_SHOW;
                  tdmt_pkg::ACT_TICK: state_in = tdmt_pkg::ST_TICK;
                  default:            state_in = tdmt_pkg::ST_EMIT;
               endcase
            end
         end
         tdmt_pkg::ST_SHOW: begin
            if (status.walk_done) begin
               // no match anywhere: take the first free slot or drop
               cmd.set_outcome = 1'b1;
               if (status.full) begin
                  cmd.outcome = tdmt_pkg::OUT_DROPPED;
               end else begin
                  cmd.insert  = 1'b1;
                  cmd.outcome = tdmt_pkg::OUT_INSERTED;
               end
               state_in = tdmt_pkg::ST_EMIT;
            end else if (status.match) begin
               cmd.refresh     = 1'b1;
               cmd.set_outcome = 1'b1;
               cmd.outcome     = tdmt_pkg::OUT_REFRESHED;
               state_in        = tdmt_pkg::ST_EMIT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         tdmt_pkg::ST_TICK: begin
            if (status.walk_done) begin
               cmd.commit = 1'b1;
               state_in   = tdmt_pkg::ST_EMIT;
            end else begin
               cmd.copy = status.keep;
               cmd.step = 1'b1;
            end
         end
         tdmt_pkg::ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = tdmt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tdmt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/tdmt_dp.sv
module tdmt_dp (
   input  logic                                clock,
   input  logic                                reset,
   // item fields
   input  logic [tdmt_pkg::ACTION_W-1:0]       req_action,
   input  logic [tdmt_pkg::MSG_W-1:0]          req_message_id,
   input  logic [tdmt_pkg::TIME_W-1:0]         req_now_ms,
   input  logic [tdmt_pkg::SLOT_W-1:0]         req_slot_index,
   // timeout register write
   input  logic                                csr_write,
   input  logic [tdmt_pkg::TIMEOUT_W-1:0]      csr_data,
   // control
   input  tdmt_pkg::dp_cmd_type                cmd,
   output tdmt_pkg::dp_status_type             status,
   // result register
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tdmt_pkg::outcome_type               rsp_outcome,
   output logic [tdmt_pkg::ACTIVE_W-1:0]       rsp_active_count,
   output logic                                rsp_read_valid,
   output logic [tdmt_pkg::MSG_W-1:0]          rsp_read_message,
   output logic [tdmt_pkg::TIME_W-1:0]         rsp_read_time
);

   localparam int IDX_W  = tdmt_pkg::IDX_W;
   localparam int CNT_W  = tdmt_pkg::CNT_W;
   localparam int MSG_W  = tdmt_pkg::MSG_W;
   localparam int TIME_W = tdmt_pkg::TIME_W;

   // entry store, packed: slots below the count are live
   logic [MSG_W-1:0]  entry_message_ff [tdmt_pkg::SLOTS];
   logic [TIME_W-1:0] entry_stamp_ff   [tdmt_pkg::SLOTS];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  dst_ff, dst_in;
   logic [tdmt_pkg::LIMIT_W-1:0] limit_ff, limit_in;

   tdmt_pkg::action_type       action_ff;
   logic [MSG_W-1:0]           id_ff;
   logic [TIME_W-1:0]          now_ff;
   logic [tdmt_pkg::SLOT_W-1:0] slot_ff;
   tdmt_pkg::outcome_type      outcome_ff;

   logic                       rsp_valid_ff;
   tdmt_pkg::outcome_type      rsp_outcome_ff;
   logic [tdmt_pkg::ACTIVE_W-1:0] rsp_count_ff;
   logic                       rsp_rvalid_ff;
   logic [MSG_W-1:0]           rsp_msg_ff;
   logic [TIME_W-1:0]          rsp_time_ff;

   logic [tdmt_pkg::CMP_W-1:0] slot_ext;
   logic [IDX_W-1:0]           rd_addr;
   logic [MSG_W-1:0]           rd_message;
   logic [TIME_W-1:0]          rd_stamp;
   logic [TIME_W-1:0]          age;
   logic                       slot_live;

   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic [MSG_W-1:0]           wr_message;
   logic [TIME_W-1:0]          wr_stamp;

   // single read port: walk index while scanning, requested slot on emit
   assign slot_ext   = tdmt_pkg::CMP_W'(slot_ff);
   assign rd_addr    = cmd.emit ? slot_ext[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign rd_message = entry_message_ff[rd_addr];
   assign rd_stamp   = entry_stamp_ff[rd_addr];
   assign age        = now_ff - rd_stamp;
   assign slot_live  = (action_ff == tdmt_pkg::ACT_READ) &&
                       (slot_ext < tdmt_pkg::CMP_W'(count_ff));

   assign status.walk_done = (idx_ff == count_ff);
   assign status.match     = (rd_message == id_ff);
   assign status.keep      = (age <= TIME_W'(limit_ff));
   assign status.full      = (count_ff == CNT_W'(tdmt_pkg::SLOTS));
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   // single write port
   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = idx_ff[IDX_W-1:0];
      wr_message = id_ff;
      wr_stamp   = now_ff;
      if (cmd.refresh) begin
         wr_en = 1'b1;
      end else if (cmd.insert) begin
         wr_en   = 1'b1;
         wr_addr = count_ff[IDX_W-1:0];
      end else if (cmd.copy) begin
         wr_en      = 1'b1;
         wr_addr    = dst_ff[IDX_W-1:0];
         wr_message = rd_message;
         wr_stamp   = rd_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_message_ff[wr_addr] <= wr_message;
         entry_stamp_ff[wr_addr]   <= wr_stamp;
      end
   end

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      dst_in   = dst_ff;
      limit_in = limit_ff;
      if (csr_write) begin
         limit_in = tdmt_pkg::LIMIT_W'(csr_data) *
                    tdmt_pkg::LIMIT_W'(tdmt_pkg::MS_PER_S);
      end
      if (cmd.load) begin
         idx_in = '0;
         dst_in = '0;
      end
      if (cmd.step) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.copy) begin
         dst_in = dst_ff + CNT_W'(1);
      end
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.commit) begin
         count_in = dst_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         limit_ff     <= tdmt_pkg::LIMIT_W'(tdmt_pkg::DEFAULT_TIMEOUT * tdmt_pkg::MS_PER_S);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         limit_ff <= limit_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      dst_ff <= dst_in;
      if (cmd.load) begin
         action_ff  <= tdmt_pkg::action_type'(req_action);
         id_ff      <= req_message_id;
         now_ff     <= req_now_ms;
         slot_ff    <= req_slot_index;
         outcome_ff <= tdmt_pkg::OUT_OTHER;
      end else if (cmd.set_outcome) begin
         outcome_ff <= cmd.outcome;
      end
      if (cmd.emit) begin
         rsp_outcome_ff <= outcome_ff;
         rsp_count_ff   <= tdmt_pkg::ACTIVE_W'(count_ff);
         rsp_rvalid_ff  <= slot_live;
         rsp_msg_ff     <= slot_live ? rd_message : '0;
         rsp_time_ff    <= slot_live ? rd_stamp : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_active_count = rsp_count_ff;
   assign rsp_read_valid   = rsp_rvalid_ff;
   assign rsp_read_message = rsp_msg_ff;
   assign rsp_read_time    = rsp_time_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(tdmt_pkg::SLOTS))
      else $error("fill count above table size");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> (count_ff < CNT_W'(tdmt_pkg::SLOTS)))
      else $error("insert into a full table");

   a_copy_down: assert property (@(posedge clock) disable iff (reset)
      cmd.copy |-> (dst_ff <= idx_ff) && (idx_ff < count_ff))
      else $error("compaction moves an entry upward or past the count");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("result lost after emit");
`endif

endmodule

// File: src/timed_dedup_message_table.sv
// Channel | Dir | Handshake             | Payload
// req     | in  | req_tvalid/req_tready | tuser: action; tdata: id, now_ms, slot
// rsp     | out | rsp_tvalid/rsp_tready | tuser: outcome, read_valid; tdata: count, read
// csr     | in  | csr_valid/csr_ready   | csr_data: timeout_seconds
//
// A show or tick walks the live slots one per cycle through the single entry
// read port, and a show stops early at a matching slot. Read and unused actions
// skip the walk and go straight to the result.
// Synchronous reset empties the table and sets the timeout to 5 s.
// A result waits in the output register; the block takes the next beat meanwhile
// and stalls only when a new result finds that register still occupied.
module timed_dedup_message_table (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tdmt_pkg::ACTION_W-1:0]         req_tuser,  // [1:0] action
   input  logic [tdmt_pkg::REQ_DATA_W-1:0]       req_tdata,  // [5:0] message_id,
                                                             // [37:6] now_ms,
                                                             // [41:38] slot_index,
                                                             // [47:42] zero
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [tdmt_pkg::RSP_USER_W-1:0]       rsp_tuser,  // [1:0] outcome,
                                                             // [2] read_valid
   output logic [tdmt_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // [3:0] active_count,
                                                             // [9:4] read_message,
                                                             // [41:10] read_time,
                                                             // [47:42] zero
   // timeout register write
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tdmt_pkg::TIMEOUT_W-1:0]        csr_data
);

   localparam int MSG_LO  = 0;
   localparam int NOW_LO  = MSG_LO + tdmt_pkg::MSG_W;
   localparam int SLOT_LO = NOW_LO + tdmt_pkg::TIME_W;
   localparam int SLOT_HI = SLOT_LO + tdmt_pkg::SLOT_W;

   localparam int RMSG_LO  = tdmt_pkg::ACTIVE_W;
   localparam int RTIME_LO = RMSG_LO + tdmt_pkg::MSG_W;
   localparam int RTIME_HI = RTIME_LO + tdmt_pkg::TIME_W;

   tdmt_pkg::dp_cmd_type    cmd;
   tdmt_pkg::dp_status_type status;

   tdmt_pkg::outcome_type              rsp_outcome;
   logic [tdmt_pkg::ACTIVE_W-1:0]      rsp_active_count;
   logic                               rsp_read_valid;
   logic [tdmt_pkg::MSG_W-1:0]         rsp_read_message;
   logic [tdmt_pkg::TIME_W-1:0]        rsp_read_time;

   // Timeout writes must land only while idle; the block does not enforce this and always takes them.
   assign csr_ready = 1'b1;

   tdmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tdmt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_tuser),
      .req_message_id   (req_tdata[NOW_LO-1:MSG_LO]),
      .req_now_ms       (req_tdata[SLOT_LO-1:NOW_LO]),
      .req_slot_index   (req_tdata[SLOT_HI-1:SLOT_LO]),
      .csr_write        (csr_valid & csr_ready),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_outcome      (rsp_outcome),
      .rsp_active_count (rsp_active_count),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_read_message (rsp_read_message),
      .rsp_read_time    (rsp_read_time)
   );

   // Pack the result beat, zero fill to whole bytes.
   assign rsp_tuser = {rsp_read_valid, rsp_outcome};
   assign rsp_tdata = {{(tdmt_pkg::RSP_DATA_W - RTIME_HI){1'b0}},
                       rsp_read_time, rsp_read_message, rsp_active_count};

endmodule

// File: bench/tb_timed_dedup_message_table.sv
module tb_timed_dedup_message_table;
   import tdmt_pkg::*;

   localparam int PHASES       = 8;
   localparam int PER_PHASE    = 250;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int SETTLE       = 20;

   typedef struct {
      action_type        act;
      logic [MSG_W-1:0]  id;
      logic [TIME_W-1:0] now;
      logic [SLOT_W-1:0] slot;
   } table_request_type;

   typedef struct {
      outcome_type          outcome;
      logic [ACTIVE_W-1:0]  active;
      logic                 hit;
      logic [MSG_W-1:0]     msg;
      logic [TIME_W-1:0]    stamp;
   } table_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ACTION_W-1:0]   req_tuser  = '0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [TIMEOUT_W-1:0]  csr_data   = '0;

   timed_dedup_message_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Shadow copy of the message table and its timeout register
   logic                 shadow_valid [SLOTS];
   logic [MSG_W-1:0]     shadow_msg   [SLOTS];
   logic [TIME_W-1:0]    shadow_stamp [SLOTS];
   logic [TIMEOUT_W-1:0] shadow_timeout = TIMEOUT_W'(DEFAULT_TIMEOUT);

   table_request_type pending_requests [$];
   table_reply_type   pending_replies  [$];
   table_request_type on_bus;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int accepted       = 0;
   int inserted       = 0;
   int refreshed      = 0;
   int dropped        = 0;
   int ticks          = 0;
   int read_hits      = 0;
   int read_misses    = 0;
   int expired        = 0;
   int checked        = 0;
   int cycle_count    = 0;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         shadow_valid[i] = 1'b0;
         shadow_msg[i]   = '0;
         shadow_stamp[i] = '0;
      end
   end

   // Apply one request to the shadow table and return the reply it produces.
   function automatic table_reply_type apply_request(table_request_type r);
      table_reply_type   y;
      logic [TIME_W-1:0] limit;
      logic [TIME_W-1:0] age;
      int                dst;
      int                fill;
      bit                done;
      y.outcome = OUT_OTHER;
      y.hit     = 1'b0;
      y.msg     = '0;
      y.stamp   = '0;
      done      = 1'b0;
      dst       = 0;
      fill      = 0;
      case (r.act)
         ACT_SHOW: begin
            y.outcome = OUT_DROPPED;
            // refresh a matching entry first, else take the first free slot
            for (int i = 0; i < SLOTS; i++) begin
               if (!done && shadow_valid[i] && shadow_msg[i] == r.id) begin
                  shadow_stamp[i] = r.now;
                  y.outcome = OUT_REFRESHED;
                  done = 1'b1;
               end
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (!done && !shadow_valid[i]) begin
                  shadow_valid[i] = 1'b1;
                  shadow_msg[i]   = r.id;
                  shadow_stamp[i] = r.now;
                  y.outcome = OUT_INSERTED;
                  done = 1'b1;
               end
            end
         end
         ACT_TICK: begin
            limit = TIME_W'(shadow_timeout) * TIME_W'(MS_PER_S);
            for (int i = 0; i < SLOTS; i++) begin
               age = r.now - shadow_stamp[i];
               if (shadow_valid[i] && age > limit) begin
                  shadow_valid[i] = 1'b0;
                  shadow_msg[i]   = '0;
                  shadow_stamp[i] = '0;
                  expired++;
               end
            end
            // compact survivors toward slot 0, keeping their order
            for (int i = 0; i < SLOTS; i++) begin
               if (shadow_valid[i]) begin
                  if (dst != i) begin
                     shadow_valid[dst] = 1'b1;
                     shadow_msg[dst]   = shadow_msg[i];
                     shadow_stamp[dst] = shadow_stamp[i];
                     shadow_valid[i]   = 1'b0;
                     shadow_msg[i]     = '0;
                     shadow_stamp[i]   = '0;
                  end
                  dst++;
               end
            end
         end
         ACT_READ: begin
            if (r.slot < SLOTS && shadow_valid[r.slot]) begin
               y.hit   = 1'b1;
               y.msg   = shadow_msg[r.slot];
               y.stamp = shadow_stamp[r.slot];
            end
         end
         default: ;
      endcase
      for (int i = 0; i < SLOTS; i++)
         if (shadow_valid[i])
            fill++;
      y.active = ACTIVE_W'(fill);
      return y;
   endfunction

   task automatic queue_request(action_type act, logic [MSG_W-1:0] id,
                                logic [TIME_W-1:0] now, logic [SLOT_W-1:0] slot);
      table_request_type r;
      r.act  = act;
      r.id   = id;
      r.now  = now;
      r.slot = slot;
      pending_requests.push_back(r);
   endtask

   // Request driver: hold a beat until taken, then predict and move on.
   always @(posedge clock) begin
      table_reply_type y;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            y = apply_request(on_bus);
            pending_replies.push_back(y);
            accepted++;
            case (on_bus.act)
               ACT_SHOW: begin
                  if (y.outcome == OUT_INSERTED) inserted++;
                  else if (y.outcome == OUT_REFRESHED) refreshed++;
                  else dropped++;
               end
               ACT_TICK: ticks++;
               ACT_READ: begin
                  if (y.hit) read_hits++;
                  else read_misses++;
               end
               default: ;
            endcase
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               on_bus = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= on_bus.act;
               req_tdata  <= {6'd0, on_bus.slot, on_bus.now, on_bus.id};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: stall at random, check each beat against the oldest reply.
   always @(posedge clock) begin
      table_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (pending_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result beat: tuser=%h tdata=%h", rsp_tuser, rsp_tdata);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_tuser[1:0]  !== want.outcome ||
                   rsp_tdata[3:0]  !== want.active  ||
                   rsp_tuser[2]    !== want.hit     ||
                   rsp_tdata[9:4]  !== want.msg     ||
                   rsp_tdata[41:10] !== want.stamp) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("result %0d exp/act: outcome %0d/%0d count %0d/%0d",
                              checked, want.outcome, rsp_tuser[1:0], want.active,
                              rsp_tdata[3:0]);
                     $display("   hit %0d/%0d msg %0d/%0d time %h/%h",
                              want.hit, rsp_tuser[2], want.msg, rsp_tdata[9:4],
                              want.stamp, rsp_tdata[41:10]);
                  end
               end
            end
         end
      end
   end

   // Watchdog: bail out if the run hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("watchdog expired after %0d cycles, %0d replies outstanding",
                  cycle_count, pending_replies.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [TIMEOUT_W-1:0] timeout_plan [PHASES];
      logic [TIME_W-1:0]    now_ms;
      logic [TIME_W-1:0]    span;
      logic [TIME_W-1:0]    step;
      int                   roll;
      timeout_plan = '{8'd5, 8'd0, 8'd255, 8'd1, 8'd0, 8'd0, 8'd255, 8'd2};
      timeout_plan[5] = TIMEOUT_W'($urandom_range(3, 254));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed opening under the reset timeout of 5 s
      queue_request(ACT_READ, 6'd0, 32'd0, 4'd0);        // empty table
      queue_request(ACT_READ, 6'd0, 32'd0, 4'd15);       // beyond the table
      queue_request(ACT_NONE, 6'd63, 32'hFFFF_FFFF, 4'd15);
      queue_request(ACT_TICK, 6'd0, 32'd0, 4'd0);
      queue_request(ACT_SHOW, 6'd0, 32'd100, 4'd0);
      queue_request(ACT_SHOW, 6'd63, 32'd200, 4'd0);
      queue_request(ACT_SHOW, 6'd0, 32'd300, 4'd0);      // refresh
      for (int i = 1; i <= 8; i++)
         queue_request(ACT_SHOW, MSG_W'(i), 32'd400, 4'd0);
      queue_request(ACT_SHOW, 6'd9, 32'd500, 4'd0);      // full: dropped
      queue_request(ACT_SHOW, 6'd63, 32'd600, 4'd0);     // refresh while full
      queue_request(ACT_READ, 6'd0, 32'd0, 4'd9);
      queue_request(ACT_READ, 6'd0, 32'd0, 4'd10);
      queue_request(ACT_TICK, 6'd0, 32'd5300, 4'd0);     // age equal to limit survives
      queue_request(ACT_TICK, 6'd0, 32'd5301, 4'd0);     // slot 0 expires, rest slide
      queue_request(ACT_READ, 6'd0, 32'd0, 4'd0);
      queue_request(ACT_READ, 6'd0, 32'd0, 4'd8);
      queue_request(ACT_TICK, 6'd0, 32'd5601, 4'd0);     // everything expires
      queue_request(ACT_SHOW, 6'd5, 32'hFFFF_FF00, 4'd0);
      queue_request(ACT_TICK, 6'd0, 32'h0000_1000, 4'd0); // age across the wrap
      queue_request(ACT_NONE, 6'd0, 32'd0, 4'd0);
      queue_request(ACT_TICK, 6'd0, 32'hFFFF_FEFF, 4'd0); // stamp ahead: huge age

      now_ms = $urandom();
      for (int phase = 0; phase < PHASES; phase++) begin
         // drain before touching the timeout register
         while (pending_requests.size() != 0 || req_tvalid || pending_replies.size() != 0)
            @(posedge clock);
         if (phase != 0) begin
            @(posedge clock);
            csr_valid <= 1'b1;
            csr_data  <= timeout_plan[phase];
            do @(posedge clock); while (!csr_ready);
            shadow_timeout = timeout_plan[phase];
            csr_valid <= 1'b0;
         end
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         span = TIME_W'(shadow_timeout) * TIME_W'(MS_PER_S);
         if ($urandom_range(0, 1) == 0)
            now_ms = 32'hFFFF_FFFF - TIME_W'($urandom_range(0, 200000));

         // Mostly coherent traffic from a small id pool with advancing time
         for (int n = 0; n < PER_PHASE; n++) begin
            roll = $urandom_range(0, 99);
            step = ($urandom_range(0, 3) == 0) ? '0 :
                   TIME_W'($urandom_range(0, span / 4 + 20));
            if (roll < 50) begin
               now_ms += step;
               queue_request(ACT_SHOW,
                             ($urandom_range(0, 99) < 85) ? MSG_W'($urandom_range(0, 13))
                                                          : MSG_W'($urandom_range(0, 63)),
                             now_ms, SLOT_W'($urandom()));
            end else if (roll < 70) begin
               now_ms += step;
               queue_request(ACT_TICK, MSG_W'($urandom()), now_ms, SLOT_W'($urandom()));
            end else if (roll < 88) begin
               queue_request(ACT_READ, MSG_W'($urandom()), $urandom(),
                             ($urandom_range(0, 99) < 85) ? SLOT_W'($urandom_range(0, 11))
                                                          : SLOT_W'($urandom()));
            end else if (roll < 93) begin
               queue_request(ACT_NONE, MSG_W'($urandom()), $urandom(), SLOT_W'($urandom()));
            end else begin
               // noise: a wild time value, sometimes adopted as the new clock
               step = $urandom();
               if ($urandom_range(0, 1) == 0)
                  now_ms = step;
               queue_request(($urandom_range(0, 1) == 0) ? ACT_SHOW : ACT_TICK,
                             MSG_W'($urandom()), step, SLOT_W'($urandom()));
            end
         end
      end

      while (pending_requests.size() != 0 || req_tvalid || pending_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("covered %0d requests, %0d timeouts: %0d inserted, %0d refreshed, %0d dropped",
               accepted, PHASES, inserted, refreshed, dropped);
      $display("%0d ticks expired %0d entries; reads hit %0d, missed %0d; %0d mismatches",
               ticks, expired, read_hits, read_misses, mismatches);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
